// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the minimum loser tree.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mlt_pkg.sv =====
// Package for the minimum loser tree: field widths, request kinds, constants.
// Used by the channel interfaces and by the top level; depends on nothing.
`default_nettype none

package mlt_pkg;

  localparam int LEAVES_DEF = 16;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 4;
  localparam int NODE_W     = 5;
  localparam int CNT_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int RESET_COUNT = 16;

  localparam logic [VALUE_W-1:0] SENT_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_UPDATE = 2'd2
  } kind_t;

endpackage

`default_nettype wire

// ===== rtl/mlt_if.sv =====
// Request and result channel interfaces of the minimum loser tree.
// Depends on mlt_pkg for the field widths.
`default_nettype none

interface mlt_req_if;
  logic                          valid;
  logic                          ready;
  logic [mlt_pkg::KIND_W-1:0]    kind;
  logic [mlt_pkg::IDX_W-1:0]     leaf_index;
  logic signed [mlt_pkg::VALUE_W-1:0] leaf_value;

  modport source (output valid, kind, leaf_index, leaf_value, input ready);
  modport sink   (input valid, kind, leaf_index, leaf_value, output ready);
endinterface

interface mlt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mlt_pkg::IDX_W-1:0]     node_position;
  logic [mlt_pkg::NODE_W-1:0]    node_leaf;
  logic signed [mlt_pkg::VALUE_W-1:0] node_value;
  logic                          last;

  modport source (output valid, node_position, node_leaf, node_value, last, input ready);
  modport sink   (input valid, node_position, node_leaf, node_value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/min_loser_tree.sv =====
// Minimum loser tree: leaf and node stores in two RAMs, one sequencer.
// Depends on mlt_pkg, the mlt_req_if / mlt_rsp_if interfaces, mlt_ram and
// assert_macros.svh.
//
//   channel   direction  handshake      payload
//   in_ch     in         valid/ready    kind, leaf_index, leaf_value
//   out_ch    out        valid/ready    node_position, node_leaf, node_value, last
//   cfg_*     in         cfg_we         cfg_wdata (leaf_count)
//
// One request at a time. A load writes the leaf RAM directly. An update is accepted,
// then climbs the tree one level at a time (node read, leaf read, compare and write),
// stores the winner and starts the report, then reports the nodes one by one.
// A build first clears n nodes, then climbs from every leaf, then reports like an
// update. The RAM reads are registered.
// A stalled result holds the report in place; a new request is taken as soon as the
// last result of the previous one sits in the output register. Reset is synchronous.
`default_nettype none
`include "assert_macros.svh"

module min_loser_tree #(
  parameter int LEAVES = mlt_pkg::LEAVES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [mlt_pkg::CNT_W-1:0]   cfg_wdata,
  mlt_req_if.sink                          in_ch,
  mlt_rsp_if.source                        out_ch
);

  import mlt_pkg::*;

  localparam int AW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int RST_N_INT = (RESET_COUNT > LEAVES) ? LEAVES : RESET_COUNT;
  localparam logic [NODE_W-1:0] RST_IDX = NODE_W'(RST_N_INT);

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_BLEAF, S_BCAP, S_NRD, S_LRD, S_CMP,
    S_FIN, S_RSTART, S_RA, S_RB
  } state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           k_r;
  logic [NODE_W-1:0]          start_r;
  logic [NODE_W-1:0]          pos_r;
  logic [NODE_W-1:0]          cur_r;
  logic signed [VALUE_W-1:0]  cur_val_r;
  logic [NODE_W-1:0]          win_r;
  logic                       build_r;
  logic [NODE_W-1:0]          ent_r;
  logic                       ent_ok_r;
  logic                       nvld_r;
  logic [LEAVES-1:0]          nvld_bits_r;

  logic                       out_valid_r;
  logic [IDX_W-1:0]           out_pos_r;
  logic [NODE_W-1:0]          out_leaf_r;
  logic signed [VALUE_W-1:0]  out_value_r;
  logic                       out_last_r;

  logic [CNT_W-1:0]           n_eff;
  logic [CNT_W-1:0]           k_inc;
  logic                       in_fire;
  logic                       slot_free;
  logic [VALUE_W-1:0]         in_val;
  logic [NODE_W-1:0]          node_entry;
  logic                       entry_ok;
  logic signed [VALUE_W-1:0]  leaf_val;
  logic                       less;
  logic [NODE_W:0]            idx_sum;
  logic [NODE_W:0]            start_sum;
  logic [NODE_W-1:0]          pos_up;

  logic                       node_we, node_re;
  logic [AW-1:0]              node_waddr, node_raddr;
  logic [NODE_W-1:0]          node_wdata, node_rdata;
  logic                       leaf_we, leaf_re;
  logic [AW-1:0]              leaf_waddr, leaf_raddr;
  logic [VALUE_W-1:0]         leaf_wdata, leaf_rdata;
  logic [NODE_W-1:0]          leaf_rindex;

  // Effective leaf count: the register saturated into [2, LEAVES].
  always_comb begin
    n_eff = count_r;
    if (count_r < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (32'(count_r) > 32'(LEAVES)) begin
      n_eff = CNT_W'(LEAVES);
    end
  end

  assign k_inc     = k_r + CNT_W'(1);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_val    = (in_ch.leaf_value == SENT_VALUE) ? (SENT_VALUE + VALUE_W'(1))
                                                      : in_ch.leaf_value;

  // A node never written since reset reads as the reset sentinel index.
  assign node_entry = nvld_r ? node_rdata : RST_IDX;
  assign entry_ok   = node_entry < n_eff;
  assign leaf_val   = ent_ok_r ? $signed(leaf_rdata) : $signed(SENT_VALUE);
  assign less       = leaf_val < cur_val_r;

  assign idx_sum   = {{(NODE_W+1-IDX_W){1'b0}}, in_ch.leaf_index} + {1'b0, n_eff};
  assign start_sum = {1'b0, start_r} + {1'b0, n_eff};
  assign pos_up    = pos_r >> 1;

  always_comb begin
    node_we     = 1'b0;
    node_waddr  = AW'(pos_r);
    node_wdata  = cur_r;
    node_re     = 1'b0;
    node_raddr  = AW'(pos_r);
    leaf_we     = 1'b0;
    leaf_waddr  = AW'(in_ch.leaf_index);
    leaf_wdata  = in_val;
    leaf_re     = 1'b0;
    leaf_rindex = start_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == KIND_LOAD) begin
            leaf_we = 32'(in_ch.leaf_index) < 32'(LEAVES);
          end else if (in_ch.kind == KIND_UPDATE) begin
            leaf_we = {1'b0, in_ch.leaf_index} < n_eff;
          end
        end
      end
      S_SWEEP: begin
        node_we    = 1'b1;
        node_waddr = AW'(k_r);
        node_wdata = n_eff;
      end
      S_BLEAF: begin
        leaf_re = 1'b1;
      end
      S_NRD: begin
        node_re = 1'b1;
      end
      S_LRD: begin
        leaf_re     = entry_ok;
        leaf_rindex = node_entry;
      end
      S_CMP: begin
        node_we = less;
      end
      S_FIN: begin
        node_we    = 1'b1;
        node_waddr = '0;
        node_wdata = win_r;
      end
      S_RSTART: begin
        node_re    = 1'b1;
        node_raddr = '0;
      end
      S_RA: begin
        leaf_re     = entry_ok;
        leaf_rindex = node_entry;
        // Fetch the next node while this one's leaf is read.
        node_re     = k_inc < n_eff;
        node_raddr  = AW'(k_inc);
      end
      default: begin
      end
    endcase
  end

  assign leaf_raddr = AW'(leaf_rindex);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(RESET_COUNT);
      nvld_bits_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (node_we) begin
        nvld_bits_r[node_waddr] <= 1'b1;
      end
      if (node_re) begin
        nvld_r <= nvld_bits_r[node_raddr];
      end
      // In S_RB the report step below decides the next output valid.
      if (out_valid_r && out_ch.ready && state_r != S_RB) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.kind == KIND_BUILD) begin
              k_r     <= '0;
              win_r   <= n_eff;
              build_r <= 1'b1;
              state_r <= S_SWEEP;
            end else if (in_ch.kind == KIND_UPDATE &&
                         {1'b0, in_ch.leaf_index} < n_eff) begin
              cur_r     <= NODE_W'(in_ch.leaf_index);
              win_r     <= NODE_W'(in_ch.leaf_index);
              cur_val_r <= $signed(in_val);
              pos_r     <= idx_sum[NODE_W:1];
              build_r   <= 1'b0;
              state_r   <= S_NRD;
            end
          end
        end
        S_SWEEP: begin
          k_r <= k_inc;
          if (k_inc == n_eff) begin
            start_r <= NODE_W'(n_eff - CNT_W'(1));
            state_r <= S_BLEAF;
          end
        end
        S_BLEAF: begin
          ent_ok_r <= 1'b1;
          state_r  <= S_BCAP;
        end
        S_BCAP: begin
          cur_r     <= start_r;
          cur_val_r <= leaf_val;
          pos_r     <= start_sum[NODE_W:1];
          state_r   <= S_NRD;
        end
        S_NRD: begin
          state_r <= S_LRD;
        end
        S_LRD: begin
          ent_r    <= node_entry;
          ent_ok_r <= entry_ok;
          state_r  <= S_CMP;
        end
        S_CMP: begin
          // A smaller node entry keeps the climber as loser and moves on up.
          if (less) begin
            win_r     <= ent_r;
            cur_r     <= ent_r;
            cur_val_r <= leaf_val;
          end
          pos_r <= pos_up;
          if (pos_up != '0) begin
            state_r <= S_NRD;
          end else if (build_r && start_r != '0) begin
            start_r <= start_r - NODE_W'(1);
            state_r <= S_BLEAF;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          k_r     <= '0;
          state_r <= S_RSTART;
        end
        S_RSTART: begin
          state_r <= S_RA;
        end
        S_RA: begin
          ent_r    <= node_entry;
          ent_ok_r <= entry_ok;
          state_r  <= S_RB;
        end
        S_RB: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= k_r[IDX_W-1:0];
            out_leaf_r  <= ent_r;
            out_value_r <= leaf_val;
            out_last_r  <= k_inc == n_eff;
            k_r         <= k_inc;
            state_r     <= (k_inc == n_eff) ? S_IDLE : S_RA;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = state_r == S_IDLE;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.node_position = out_pos_r;
  assign out_ch.node_leaf     = out_leaf_r;
  assign out_ch.node_value    = out_value_r;
  assign out_ch.last          = out_last_r;

  mlt_ram #(.WIDTH(NODE_W), .DEPTH(LEAVES), .AW(AW)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  mlt_ram #(.WIDTH(VALUE_W), .DEPTH(LEAVES), .AW(AW)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .re    (leaf_re),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  `ASSERT_IMPLIES(a_node_same_addr, clk, rst_n, node_we && node_re, node_waddr != node_raddr)
  `ASSERT_IMPLIES(a_climb_pos_range, clk, rst_n, state_r == S_NRD, pos_r != '0 && pos_r < n_eff)
  `ASSERT_IMPLIES(a_leaf_read_range, clk, rst_n, leaf_re, leaf_rindex < n_eff)
  `ASSERT_IMPLIES(a_report_index, clk, rst_n, state_r == S_RA || state_r == S_RB, k_r < n_eff)
  `ASSERT_NEXT(a_last_ends_report, clk, rst_n, state_r == S_RB && slot_free && k_inc == n_eff, state_r == S_IDLE && out_last_r)

endmodule

`default_nettype wire

// ===== rtl/mlt_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module mlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for min_loser_tree: a directed table, then random
// request traffic under varied leaf_count settings with input and output pacing.
// Depends on mlt_pkg and the mlt_req_if / mlt_rsp_if interfaces of the RTL.
`timescale 1ns / 100ps

module tb;
  import mlt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int REQUEST_GOAL  = 500;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int TIMEOUT_NS    = 30_000_000;

  typedef struct {
    logic [IDX_W-1:0]          position;
    logic [NODE_W-1:0]         leaf;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } node_report_t;

  typedef struct packed {
    bit                 count_write;
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    logic [NODE_W-1:0]  win_leaf;
    logic [VALUE_W-1:0] win_value;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_wdata;

  mlt_req_if in_ch ();
  mlt_rsp_if out_ch ();

  min_loser_tree u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  // Shadow of the tree, kept current at every accepted request.
  logic signed [VALUE_W-1:0] leaf_mem [LEAVES_DEF];
  logic [NODE_W-1:0]         node_mem [LEAVES_DEF];
  logic [CNT_W-1:0]          count_reg;
  node_report_t              node_reports[$];

  // Hand-written winner for the request currently offered, if any.
  bit                 typed_row;
  logic [NODE_W-1:0]  typed_leaf;
  logic [VALUE_W-1:0] typed_value;

  int mismatches, items_effective, nodes_checked, reports_done;
  int input_stalls, count_writes, burst_left;
  int holds_asked, holds_served;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("tb: mismatch at %0t: %s", $time, what);
  endtask

  function automatic int count_in_use();
    if (count_reg < 2) return 2;
    if (count_reg > LEAVES_DEF) return LEAVES_DEF;
    return count_reg;
  endfunction

  // Indexes at or above the count in use read as the most negative value.
  function automatic logic signed [VALUE_W-1:0] leaf_val(input int leaf, input int n);
    if (leaf < n) return leaf_mem[leaf];
    return SENT_VALUE;
  endfunction

  // One climb from a leaf to the root; a smaller node entry keeps the
  // climber as its loser and moves on up itself.
  function automatic int climb_from(input int start, input int n, input int winner);
    int pos, cur, win;
    logic signed [VALUE_W-1:0] cur_v, node_v;
    pos = (start + n) >> 1;
    cur = start;
    win = winner;
    cur_v = leaf_val(start, n);
    node_v = leaf_val(node_mem[pos], n);
    while (pos > 0) begin
      if (node_v < cur_v) begin
        win = node_mem[pos];
        node_mem[pos] = NODE_W'(cur);
        cur = win;
        cur_v = leaf_val(win, n);
      end
      pos = pos >> 1;
      node_v = leaf_val(node_mem[pos], n);
    end
    return win;
  endfunction

  // Applies one request to the shadow tree and, for a build or an update, queues its node report.
  // Returns 0 when the block ignores the request.
  function automatic bit apply_request(input logic [KIND_W-1:0] kind,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [VALUE_W-1:0] raw);
    int n, win, base, i, k;
    logic signed [VALUE_W-1:0] v;
    node_report_t entry;
    n = count_in_use();
    v = (raw == SENT_VALUE) ? SENT_VALUE + 1 : raw;
    case (kind)
      KIND_LOAD: begin
        leaf_mem[idx] = v;
        return 1'b1;
      end
      KIND_BUILD: begin
        for (i = 0; i < n; i++) node_mem[i] = NODE_W'(n);
        win = n;
        for (i = n; i > 0; i--) win = climb_from(i - 1, n, win);
        node_mem[0] = NODE_W'(win);
      end
      KIND_UPDATE: begin
        if (idx >= n) return 1'b0;
        leaf_mem[idx] = v;
        node_mem[0] = NODE_W'(climb_from(idx, n, idx));
      end
      default: return 1'b0;
    endcase
    base = node_reports.size();
    for (k = 0; k < n; k++) begin
      entry.position = IDX_W'(k);
      entry.leaf = node_mem[k];
      entry.value = leaf_val(node_mem[k], n);
      entry.last = (k == n - 1);
      node_reports.push_back(entry);
    end
    if (typed_row) begin
      node_reports[base].leaf = typed_leaf;
      node_reports[base].value = typed_value;
    end
    return 1'b1;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return SENT_VALUE;
      1: return SENT_VALUE + 1;
      2: return 32'h7FFF_FFFF;
      3, 4, 5: return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin : scoreboard
    node_report_t want;
    if (rst_n) begin
      if (cfg_we) count_reg = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        if (apply_request(in_ch.kind, in_ch.leaf_index, in_ch.leaf_value)) items_effective++;
      end else if (in_ch.valid) begin
        input_stalls++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (node_reports.size() == 0) begin
          flag_mismatch($sformatf("node %0d reported with nothing expected",
                                  out_ch.node_position));
        end else begin
          want = node_reports.pop_front();
          nodes_checked++;
          if (out_ch.node_position !== want.position)
            flag_mismatch($sformatf("position %0d, expected %0d",
                                    out_ch.node_position, want.position));
          if (out_ch.node_leaf !== want.leaf)
            flag_mismatch($sformatf("node %0d leaf %0d, expected %0d",
                                    want.position, out_ch.node_leaf, want.leaf));
          if (out_ch.node_value !== want.value)
            flag_mismatch($sformatf("node %0d value %0d, expected %0d",
                                    want.position, out_ch.node_value, want.value));
          if (out_ch.last !== want.last)
            flag_mismatch($sformatf("node %0d last %b, expected %b",
                                    want.position, out_ch.last, want.last));
          if (want.last) reports_done++;
        end
      end
    end
  end

  // Receiver: a rotating stall mask, redrawn from a fixed set or at random, plus the long hold-off.
  initial begin : result_pacing
    logic [15:0] stall_mask;
    int step;
    out_ch.ready = 1'b0;
    stall_mask = 16'hFFFF;
    step = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_served++;
      end else begin
        if (step % 64 == 0) begin
          case ($urandom_range(0, 4))
            0: stall_mask = 16'hFFFF;
            1: stall_mask = 16'hAAAA;
            2: stall_mask = 16'h8421;
            3: stall_mask = 16'h0001;
            default: stall_mask = 16'($urandom());
          endcase
        end
        out_ch.ready <= stall_mask[step % 16];
        step++;
      end
    end
  end

  // Offers one request at a falling edge and returns at the falling edge
  // after it is accepted. Bursts of requests alternate with random gaps.
  task automatic put_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                             input logic [VALUE_W-1:0] value, input bit typed = 1'b0,
                             input logic [NODE_W-1:0] t_leaf = '0,
                             input logic [VALUE_W-1:0] t_value = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    typed_row = typed;
    typed_leaf = t_leaf;
    typed_value = t_value;
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.leaf_index <= idx;
    in_ch.leaf_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Holds requests back until every node report is in, then lets a load finish.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (node_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] count);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we <= 1'b0;
    count_writes++;
  endtask

  initial begin : stimulus
    plan_row_t plan[$];
    int count_plan[$];
    int n, pick, goal, phase, target, w;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.leaf_index = '0;
    in_ch.leaf_value = '0;
    count_reg = CNT_W'(RESET_COUNT);
    foreach (leaf_mem[i]) leaf_mem[i] = '0;
    foreach (node_mem[i]) node_mem[i] = NODE_W'(RESET_COUNT);
    count_plan = '{16, 2, 0, 31, 1, 17, 3, 8, 5, 16};

    // The first update after reset meets only sentinel nodes, so the sentinel
    // itself climbs out as the winner. Leaf 0 and leaf 15 get the clamped
    // sentinel value; leaves 8 and 11 tie.
    plan = '{
      '{1'b0, KIND_UPDATE, 4'd0,  32'd100,      1'b1, 5'd16, SENT_VALUE},
      '{1'b0, KIND_LOAD,   4'd0,  SENT_VALUE,   1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_LOAD,   4'd1,  32'h7FFF_FFFF, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd2,  32'd0,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_LOAD,   4'd3,  32'hFFFF_FFFF, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd4,  32'd1,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_LOAD,   4'd5,  32'h8000_0002, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd6,  32'd42,       1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_LOAD,   4'd7,  32'hFFFF_FF00, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd8,  32'd7,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_LOAD,   4'd9,  32'h1234_5678, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd10, 32'hDEAD_BEEF, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd11, 32'd7,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_LOAD,   4'd12, 32'h0000_FFFF, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd13, 32'hC000_0000, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd14, 32'h4000_0000, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_LOAD,   4'd15, SENT_VALUE,   1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_BUILD,  4'd0,  32'd0,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_UPDATE, 4'd0,  32'h7FFF_FFFF, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_SPARE,  4'd5,  32'd0,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_UPDATE, 4'd3,  SENT_VALUE,   1'b0, 5'd0,  32'd0},
      '{1'b1, KIND_LOAD,   4'd0,  32'd4,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_UPDATE, 4'd9,  32'd0,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_UPDATE, 4'd1,  32'hFFFF_FFFB, 1'b0, 5'd0, 32'd0},
      '{1'b0, KIND_BUILD,  4'd15, 32'hFFFF_FFFF, 1'b0, 5'd0, 32'd0},
      '{1'b1, KIND_LOAD,   4'd0,  32'd0,        1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_BUILD,  4'd0,  32'd0,        1'b0, 5'd0,  32'd0},
      '{1'b1, KIND_LOAD,   4'd0,  32'd31,       1'b0, 5'd0,  32'd0},
      '{1'b0, KIND_BUILD,  4'd0,  32'd0,        1'b0, 5'd0,  32'd0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].count_write) begin
        wait_quiet();
        write_count(plan[r].value[CNT_W-1:0]);
      end else begin
        put_request(plan[r].kind, plan[r].idx, plan[r].value, plan[r].typed,
                    plan[r].win_leaf, plan[r].win_value);
      end
    end

    phase = 0;
    while (items_effective < REQUEST_GOAL) begin
      wait_quiet();
      write_count(CNT_W'(phase < count_plan.size() ? count_plan[phase]
                                                   : $urandom_range(0, 31)));
      phase++;
      n = count_in_use();
      goal = items_effective + $urandom_range(20, 60);
      while (items_effective < goal && items_effective < REQUEST_GOAL) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // Well-formed sequence: refresh some leaves, build, then replay the winner.
          repeat ($urandom_range(1, 4))
            put_request(KIND_LOAD, IDX_W'($urandom_range(0, n - 1)), pick_value());
          // The receiver stops once for a long stretch while requests keep coming.
          if (holds_asked == 0 && items_effective >= 200) holds_asked = 1;
          put_request(KIND_BUILD, IDX_W'($urandom_range(0, 15)), $urandom());
          repeat ($urandom_range(1, 3)) begin
            target = (node_mem[0] < n) ? node_mem[0] : $urandom_range(0, n - 1);
            put_request(KIND_UPDATE, IDX_W'(target), pick_value());
          end
        end else if (pick < 75) begin
          put_request(KIND_UPDATE, IDX_W'($urandom_range(0, n - 1)), pick_value());
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 3))
            put_request(KIND_LOAD, IDX_W'($urandom_range(0, 15)), pick_value());
        end else if (pick < 93) begin
          target = (n < LEAVES_DEF) ? $urandom_range(n, 15) : $urandom_range(0, 15);
          put_request(KIND_UPDATE, IDX_W'(target), pick_value());
        end else if (pick < 97) begin
          put_request(KIND_SPARE, IDX_W'($urandom_range(0, 15)), $urandom());
        end else begin
          wait_quiet();
        end
      end
    end

    in_ch.valid <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && node_reports.size() != 0; w++) @(negedge clk);
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (node_reports.size() != 0)
      flag_mismatch($sformatf("%0d node reports never arrived", node_reports.size()));

    $display("tb: %0d requests took effect under %0d leaf_count writes, %0d nodes checked",
             items_effective, count_writes, nodes_checked);
    $display("tb: %0d complete tree reports, %0d request stall cycles, %0d mismatches",
             reports_done, input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: run did not finish by %0t", $time);
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== min_loser_tree.f =====
+incdir+rtl
rtl/mlt_pkg.sv
rtl/mlt_if.sv
rtl/mlt_ram.sv
rtl/min_loser_tree.sv
verif/tb.sv
